// ===== hdl/lbta_pkg.sv =====
package lbta_pkg;

  // Width of a block number, a link entry and the free count.
  localparam int BLK_W = 13;
  // Default number of blocks in the table.
  localparam int TABLE_BLOCKS_DEF = 4096;
  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 32;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOSPACE  = 3'd1,
    ST_BADARG   = 3'd2,
    ST_BROKEN   = 3'd3,
    ST_MISMATCH = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    clr_step;
    logic    scan_init;
    logic    scan_step;
    logic    tail_wr;
    logic    rel_init;
    logic    walk_init;
    logic    walk_step;
    logic    set_res;
    status_t res_code;
    logic    res_add;
    logic    res_sub;
    logic    res_head;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic func;
    logic n_zero;
    logic n_over;
    logic start_bad;
    logic found;
    logic found_last;
    logic table_end;
    logic got_zero;
    logic link_zero;
    logic link_self;
    logic link_over;
    logic walk_bound;
    logic mismatch;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/lbta_ram.sv =====
module lbta_ram #(
  parameter int WIDTH = lbta_pkg::BLK_W,
  parameter int DEPTH = lbta_pkg::TABLE_BLOCKS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/lbta_ctrl.sv =====
module lbta_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  lbta_pkg::sts_t sts,
  output lbta_pkg::cmd_t cmd
);
  import lbta_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_TAIL  = 8'b0001_0000,
    S_REL   = 8'b0010_0000,
    S_WALK  = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   rel_mode, rel_mode_next;

  // State and walk mode registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      rel_mode <= 1'b0;
    end else begin
      state    <= state_next;
      rel_mode <= rel_mode_next;
    end
  end

  assign s_axis_tready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next    = state;
    rel_mode_next = rel_mode;
    cmd           = '0;
    cmd.res_code  = ST_OK;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.func) begin
          if (sts.n_zero) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_BADARG;
            state_next   = S_FIN;
          end else if (sts.n_over) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_NOSPACE;
            state_next   = S_FIN;
          end else begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
        end else begin
          if (sts.start_bad) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_BADARG;
            state_next   = S_FIN;
          end else begin
            cmd.walk_init = 1'b1;
            rel_mode_next = 1'b0;
            state_next    = S_WALK;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.found_last) begin
          state_next = S_TAIL;
        end else if (sts.table_end) begin
          if (sts.got_zero && !sts.found) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_NOSPACE;
            state_next   = S_FIN;
          end else begin
            state_next = S_REL;
          end
        end
      end
      S_TAIL: begin
        cmd.tail_wr  = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = ST_OK;
        cmd.res_sub  = 1'b1;
        cmd.res_head = 1'b1;
        state_next   = S_FIN;
      end
      S_REL: begin
        cmd.rel_init  = 1'b1;
        rel_mode_next = 1'b1;
        state_next    = S_WALK;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        cmd.res_add   = !rel_mode;
        if (sts.link_zero || sts.link_over || sts.walk_bound) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = rel_mode ? ST_NOSPACE : ST_BROKEN;
          state_next   = S_FIN;
        end
        // The tail takes precedence over the walk bound.
        if (!sts.link_zero && sts.link_self) begin
          cmd.set_res = 1'b1;
          if (rel_mode) begin
            cmd.res_code = ST_NOSPACE;
          end else if (sts.mismatch) begin
            cmd.res_code = ST_MISMATCH;
          end else begin
            cmd.res_code = ST_OK;
          end
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A failed allocation that is rolled back always reports lack of space.
  a_rel_nospace: assert property (@(posedge clk) disable iff (rst)
    (rel_mode && state == S_WALK && cmd.set_res) |-> (cmd.res_code == ST_NOSPACE))
    else $error("rollback walk ended with a status other than no space");

endmodule

// ===== hdl/lbta_dp.sv =====
module lbta_dp #(
  parameter int TABLE_BLOCKS = lbta_pkg::TABLE_BLOCKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lbta_pkg::cmd_t                   cmd,
  output lbta_pkg::sts_t                   sts,
  input  logic [lbta_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lbta_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import lbta_pkg::*;

  localparam int IW = (TABLE_BLOCKS > 1) ? $clog2(TABLE_BLOCKS) : 1;
  localparam logic [BLK_W-1:0] TB = BLK_W'(TABLE_BLOCKS);
  localparam logic [BLK_W-1:0] ONE = BLK_W'(1);

  // Request registers.
  logic             func;
  logic [BLK_W-1:0] count;
  logic [BLK_W-1:0] start;

  // Working registers.
  logic [BLK_W-1:0] cnt;
  logic [IW-1:0]    clr_idx;
  logic [BLK_W-1:0] scan_b;
  logic [BLK_W-1:0] prev;
  logic [BLK_W-1:0] head;
  logic [BLK_W-1:0] got;
  logic [BLK_W-1:0] cur;
  logic [BLK_W-1:0] walked;

  // Pending result.
  status_t res_code;
  logic    res_add;
  logic    res_sub;
  logic    res_head;

  // Output register.
  status_t          status_out;
  logic [BLK_W-1:0] head_out;
  logic [BLK_W-1:0] free_out;

  // Table memory signals.
  logic             we;
  logic [IW-1:0]    waddr;
  logic [BLK_W-1:0] wdata;
  logic [IW-1:0]    raddr;
  logic [BLK_W-1:0] rdata;

  logic [BLK_W-1:0] prev_m1;
  logic [BLK_W-1:0] cur_m1;
  logic [BLK_W-1:0] start_m1;
  logic [BLK_W-1:0] head_m1;
  logic [BLK_W-1:0] link_m1;
  logic [BLK_W-1:0] cnt_next;

  assign prev_m1  = prev - ONE;
  assign cur_m1   = cur - ONE;
  assign start_m1 = start - ONE;
  assign head_m1  = head - ONE;
  assign link_m1  = rdata - ONE;

  // Status toward the controller.
  always_comb begin
    sts            = '0;
    sts.clr_last   = (clr_idx == IW'(TABLE_BLOCKS - 1));
    sts.func       = func;
    sts.n_zero     = (count == '0);
    sts.n_over     = (count > cnt);
    sts.start_bad  = (start == '0) || (start > TB);
    sts.found      = (rdata == '0);
    sts.found_last = (rdata == '0) && ((got + ONE) == count);
    sts.table_end  = (scan_b == TB);
    sts.got_zero   = (got == '0);
    sts.link_zero  = (rdata == '0);
    sts.link_self  = (rdata == cur);
    sts.link_over  = (rdata > TB);
    sts.walk_bound = ((walked + ONE) == TB);
    sts.mismatch   = ((walked + ONE) != count);
    sts.out_free   = !m_axis_tvalid || m_axis_tready;
  end

  // Read address selection; the walk follows the link just read.
  always_comb begin
    raddr = scan_b[IW-1:0];
    if (cmd.scan_init) begin
      raddr = '0;
    end else if (cmd.walk_init) begin
      raddr = start_m1[IW-1:0];
    end else if (cmd.rel_init) begin
      raddr = head_m1[IW-1:0];
    end else if (cmd.walk_step) begin
      raddr = link_m1[IW-1:0];
    end
  end

  // Write port selection.
  always_comb begin
    we    = 1'b0;
    waddr = clr_idx;
    wdata = '0;
    if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.scan_step && sts.found && !sts.got_zero) begin
      we    = 1'b1;
      waddr = prev_m1[IW-1:0];
      wdata = scan_b;
    end else if (cmd.tail_wr) begin
      we    = 1'b1;
      waddr = prev_m1[IW-1:0];
      wdata = prev;
    end else if (cmd.walk_step && !sts.link_zero) begin
      we    = 1'b1;
      waddr = cur_m1[IW-1:0];
    end
  end

  lbta_ram #(
    .WIDTH (BLK_W),
    .DEPTH (TABLE_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Free count after the finished request.
  always_comb begin
    cnt_next = cnt;
    if (res_add) begin
      cnt_next = cnt_next + walked;
    end
    if (res_sub) begin
      cnt_next = cnt_next - count;
    end
  end

  // Control state: clearing address, free count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx       <= '0;
      cnt           <= TB;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_idx <= clr_idx + IW'(1);
      end
      if (cmd.out_load) begin
        cnt           <= cnt_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Request capture, scan, walk and result registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func  <= s_axis_tdata[0];
      count <= s_axis_tdata[BLK_W:1];
      start <= s_axis_tdata[2*BLK_W:BLK_W+1];
    end
    if (cmd.scan_init) begin
      scan_b <= ONE;
      got    <= '0;
      head   <= '0;
    end
    if (cmd.scan_step) begin
      scan_b <= scan_b + ONE;
      if (sts.found) begin
        if (sts.got_zero) begin
          head <= scan_b;
        end
        prev <= scan_b;
        got  <= got + ONE;
      end
    end
    if (cmd.walk_init) begin
      cur    <= start;
      walked <= '0;
    end
    if (cmd.rel_init) begin
      cur    <= head;
      walked <= '0;
    end
    if (cmd.walk_step && !sts.link_zero) begin
      cur    <= rdata;
      walked <= walked + ONE;
    end
    if (cmd.set_res) begin
      res_code <= cmd.res_code;
      res_add  <= cmd.res_add;
      res_sub  <= cmd.res_sub;
      res_head <= cmd.res_head;
    end
    if (cmd.out_load) begin
      status_out <= res_code;
      head_out   <= res_head ? head : '0;
      free_out   <= cnt_next;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - 2*BLK_W - 3){1'b0}}, free_out, head_out, status_out};

  // Only a successful allocation reports a head block.
  a_head_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && head_out != '0) |-> (status_out == ST_OK))
    else $error("head block reported with a failing status");

  // The free count can never exceed the table size.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (free_out <= TB))
    else $error("free count above table size");

  // Links built by the scan always point to a higher block.
  a_link_up: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_step && sts.found && !sts.got_zero) |-> (prev < scan_b))
    else $error("scan built a link that does not point upward");

endmodule

// ===== hdl/linked_block_table_allocator_unit.sv =====
// Linked block table allocator: keeps a chained block table plus a free count.
// Input channel s_axis carries one request per transaction: allocate a chain of
// block_count blocks, or free the chain that starts at start_block. Output
// channel m_axis carries exactly one result per request: status, head block of
// a new chain and the free count after the request.
// After reset the table is swept to free, one entry per cycle; s_axis_tready
// stays low until the sweep ends.
// One request is in work at a time. An allocate scans the table entries in
// order up to the last block taken (at most TABLE_BLOCKS); a free reads the
// chain entry by entry, the entry that ends the walk included. The table
// memory has a single read port, one access per cycle.
// Argument errors and an allocate larger than the free count go from the
// check straight to the result. The next request is accepted at the earliest
// in the cycle after a result loads.
// The result sits in an output register. A new request is accepted while that
// result waits; a stalled receiver only holds the next result in its final
// cycle until the register is taken.
module linked_block_table_allocator_unit #(
  parameter int TABLE_BLOCKS = lbta_pkg::TABLE_BLOCKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0 up: func[0], block_count[13:1], start_block[26:14].
  input  logic [lbta_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0 up: status[2:0], head_block[15:3], free_blocks[28:16].
  output logic [lbta_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import lbta_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lbta_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  lbta_dp #(
    .TABLE_BLOCKS (TABLE_BLOCKS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
